FILE: rtl/xeu_pkg.sv
// Shared types and entity tables for the XML entity unescape stream core.
`default_nettype none
package xeu_pkg;

	localparam int HELD_DEPTH  = 5;
	localparam int MAX_RESULTS = 6;
	localparam int ENT_COUNT   = 4;

	localparam logic [7:0] CH_AMP  = 8'h26;
	localparam logic [7:0] CH_SEMI = 8'h3b;
	localparam logic [7:0] CH_LT   = 8'h3c;
	localparam logic [7:0] CH_GT   = 8'h3e;
	localparam logic [7:0] CH_QUOT = 8'h22;
	localparam logic [7:0] CH_A    = 8'h61;
	localparam logic [7:0] CH_M    = 8'h6d;
	localparam logic [7:0] CH_P    = 8'h70;
	localparam logic [7:0] CH_L    = 8'h6c;
	localparam logic [7:0] CH_T    = 8'h74;
	localparam logic [7:0] CH_G    = 8'h67;
	localparam logic [7:0] CH_Q    = 8'h71;
	localparam logic [7:0] CH_U    = 8'h75;
	localparam logic [7:0] CH_O    = 8'h6f;

	typedef logic [7:0] xeu_byte_t;
	typedef logic [2:0] xeu_cnt_t;

	// entity spellings, padded with zero past their size
	localparam xeu_byte_t ENT_TEXT [ENT_COUNT][MAX_RESULTS] = '{
		'{CH_AMP, CH_A, CH_M, CH_P, CH_SEMI, 8'h00},
		'{CH_AMP, CH_L, CH_T, CH_SEMI, 8'h00, 8'h00},
		'{CH_AMP, CH_G, CH_T, CH_SEMI, 8'h00, 8'h00},
		'{CH_AMP, CH_Q, CH_U, CH_O, CH_T, CH_SEMI}
	};
	localparam xeu_cnt_t  ENT_SIZE [ENT_COUNT] = '{3'd5, 3'd4, 3'd4, 3'd6};
	localparam xeu_byte_t ENT_CHAR [ENT_COUNT] = '{CH_AMP, CH_LT, CH_GT, CH_QUOT};

	// one step's worth of output bytes, handed from front to back
	typedef struct packed {
		logic [MAX_RESULTS-1:0][7:0] bytes;
		xeu_cnt_t                    count;
		logic                        last;
	} xeu_cmd_t;

endpackage
`default_nettype wire

FILE: rtl/xeu_in_if.sv
// Input channel of raw escaped bytes.
`default_nettype none
interface xeu_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;

	modport source (output valid, output in_byte, output in_last, input ready);
	modport sink (input valid, input in_byte, input in_last, output ready);
endinterface
`default_nettype wire

FILE: rtl/xeu_out_if.sv
// Output channel of unescaped bytes.
`default_nettype none
interface xeu_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       out_last;

	modport source (output valid, output out_byte, output out_last, input ready);
	modport sink (input valid, input out_byte, input out_last, output ready);
endinterface
`default_nettype wire

FILE: rtl/xeu_front.sv
// Front end: matches input bytes against the entities and builds output commands.
`default_nettype none
module xeu_front import xeu_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	xeu_in_if.sink         raw,
	input  wire logic      cmd_ready,
	output logic           cmd_valid,
	output xeu_cmd_t       cmd
);

	xeu_byte_t held_q [HELD_DEPTH];
	xeu_cnt_t  held_cnt_q;

	xeu_byte_t cand [MAX_RESULTS];
	xeu_cnt_t  len;
	logic      full;
	logic      prefix;
	xeu_byte_t full_char;
	logic      accept;

	always_comb begin
		logic mism;
		full      = 1'b0;
		prefix    = 1'b0;
		full_char = CH_AMP;
		len       = 3'(held_cnt_q + 3'd1);
		for (int i = 0; i < HELD_DEPTH; i++) begin
			if (3'(i) < held_cnt_q)
				cand[i] = held_q[i];
			else
				cand[i] = raw.in_byte;
		end
		cand[HELD_DEPTH] = raw.in_byte;
		for (int k = 0; k < ENT_COUNT; k++) begin
			mism = 1'b0;
			for (int i = 0; i < MAX_RESULTS; i++) begin
				if (3'(i) < len && cand[i] != ENT_TEXT[k][i])
					mism = 1'b1;
			end
			if (!mism && len <= ENT_SIZE[k]) begin
				if (len == ENT_SIZE[k]) begin
					full      = 1'b1;
					full_char = ENT_CHAR[k];
				end else begin
					prefix = 1'b1;
				end
			end
		end
	end

	assign raw.ready = cmd_ready;
	assign accept    = raw.valid && raw.ready;

	// the emitted bytes are always the candidate run, unless an entity completed
	always_comb begin
		for (int i = 0; i < MAX_RESULTS; i++)
			cmd.bytes[i] = cand[i];
		cmd.last = raw.in_last;
		if (full) begin
			cmd.bytes[0] = full_char;
			cmd.count    = 3'd1;
		end else if (raw.in_last) begin
			cmd.count = len;
		end else if (prefix && held_cnt_q < 3'(HELD_DEPTH)) begin
			cmd.count = 3'd0;
		end else if (raw.in_byte == CH_AMP) begin
			cmd.count = held_cnt_q;
		end else begin
			cmd.count = len;
		end
	end

	assign cmd_valid = accept && cmd.count != 3'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_cnt_q <= 3'd0;
		end else if (accept) begin
			if (full || raw.in_last)
				held_cnt_q <= 3'd0;
			else if (prefix && held_cnt_q < 3'(HELD_DEPTH))
				held_cnt_q <= len;
			else if (raw.in_byte == CH_AMP)
				held_cnt_q <= 3'd1;
			else
				held_cnt_q <= 3'd0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !full && !raw.in_last) begin
			if (prefix && held_cnt_q < 3'(HELD_DEPTH))
				held_q[held_cnt_q] <= raw.in_byte;
			else if (raw.in_byte == CH_AMP)
				held_q[0] <= CH_AMP;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/xeu_fifo.sv
// Short command queue between front and back.
`default_nettype none
module xeu_fifo import xeu_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  wire xeu_cmd_t  push_data,
	output logic           push_ready,
	input  wire logic      pop,
	output logic           pop_valid,
	output xeu_cmd_t       pop_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	xeu_cmd_t           mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   fill_q;
	logic               do_push;
	logic               do_pop;

	assign push_ready = fill_q != CNT_W'(DEPTH);
	assign pop_valid  = fill_q != '0;
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_q + 1'b1);
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_q + 1'b1);
			if (do_push && !do_pop)
				fill_q <= CNT_W'(fill_q + 1'b1);
			else if (do_pop && !do_push)
				fill_q <= CNT_W'(fill_q - 1'b1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_data;
	end

endmodule
`default_nettype wire

FILE: rtl/xeu_back.sv
// Back end: plays each command out one byte per transfer.
`default_nettype none
module xeu_back import xeu_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      cmd_valid,
	input  wire xeu_cmd_t  cmd,
	output logic           cmd_pop,
	xeu_out_if.source      text
);

	xeu_cmd_t cur_q;
	xeu_cnt_t idx_q;
	logic     busy_q;
	logic     at_end;
	logic     xfer;
	logic     done;

	assign at_end = idx_q == 3'(cur_q.count - 3'd1);
	assign xfer   = busy_q && text.ready;
	assign done   = xfer && at_end;
	assign cmd_pop = (!busy_q || done) && cmd_valid;

	assign text.valid    = busy_q;
	assign text.out_byte = cur_q.bytes[idx_q];
	assign text.out_last = cur_q.last && at_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= 3'd0;
		end else if (cmd_pop) begin
			busy_q <= 1'b1;
			idx_q  <= 3'd0;
		end else if (done) begin
			busy_q <= 1'b0;
		end else if (xfer) begin
			idx_q <= 3'(idx_q + 3'd1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop)
			cur_q <= cmd;
	end

endmodule
`default_nettype wire

FILE: rtl/xml_entity_unescape_stream_core.sv
// Top level of the XML entity unescape stream core.
//
// Channels: raw carries escaped text bytes (in_byte) with in_last on the final
// byte of a string; text carries unescaped bytes (out_byte) with out_last on the
// final byte of the string. Both are valid/ready, a transfer when both are high.
// The four entities &amp; &lt; &gt; &quot; become & < > and a double quote;
// bytes that start but break an entity pass through unchanged.
// Throughput: one input byte per cycle while the output side keeps pace; an
// input byte that releases k bytes (k from 0 to 6) occupies the output stage
// until all k are transferred. The command queue (QUEUE_DEPTH entries) absorbs
// such bursts, and raw.ready drops only while the queue is full.
// Path: with the queue empty and the output stage idle, the first byte of a
// result is written to the queue at its input transfer and then loaded into the
// output register, from which it is valid on text.
// Reset clears the held-byte count, the queue and the output stage; no clearing
// pass is needed. While the receiver stalls, the output byte holds and the
// front keeps taking input until the queue fills.
`default_nettype none
module xml_entity_unescape_stream_core import xeu_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic clk,
	input  wire logic arst_n,
	xeu_in_if.sink    raw,
	xeu_out_if.source text
);

	xeu_cmd_t front_cmd;
	xeu_cmd_t queue_cmd;
	logic     front_valid;
	logic     queue_ready;
	logic     queue_valid;
	logic     queue_pop;

	xeu_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.raw       (raw),
		.cmd_ready (queue_ready),
		.cmd_valid (front_valid),
		.cmd       (front_cmd)
	);

	xeu_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (front_valid),
		.push_data  (front_cmd),
		.push_ready (queue_ready),
		.pop        (queue_pop),
		.pop_valid  (queue_valid),
		.pop_data   (queue_cmd)
	);

	xeu_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (queue_valid),
		.cmd       (queue_cmd),
		.cmd_pop   (queue_pop),
		.text      (text)
	);

endmodule
`default_nettype wire

FILE: rtl/xeu_chk.sv
// Port-level checks for the XML entity unescape stream core, with its bind.
`default_nettype none
module xeu_chk (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       raw_valid,
	input wire logic       raw_ready,
	input wire logic       raw_last,
	input wire logic       text_valid,
	input wire logic       text_ready,
	input wire logic [7:0] text_byte,
	input wire logic       text_last
);

	// hold the output item while the receiver stalls
	a_text_hold: assert property (@(posedge clk) disable iff (!arst_n)
		text_valid && !text_ready |=> text_valid && $stable(text_byte) && $stable(text_last))
		else $error("output item changed during stall");

	// input backpressure only comes from a full queue, so output must be pending
	a_stall_has_output: assert property (@(posedge clk) disable iff (!arst_n)
		!raw_ready |-> text_valid)
		else $error("input stalled with no output pending");

	// a final input byte always releases at least one byte, through queue and output stage
	a_last_emits: assert property (@(posedge clk) disable iff (!arst_n)
		raw_valid && raw_ready && raw_last |-> ##2 text_valid)
		else $error("final input byte produced no output");

endmodule

bind xml_entity_unescape_stream_core xeu_chk u_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.raw_valid  (raw.valid),
	.raw_ready  (raw.ready),
	.raw_last   (raw.in_last),
	.text_valid (text.valid),
	.text_ready (text.ready),
	.text_byte  (text.out_byte),
	.text_last  (text.out_last)
);
`default_nettype wire

FILE: sim/tb.sv
// Testbench for the XML entity unescape stream core: entity decode, flush on last, stalls.
`timescale 1ns / 1ps

module tb import xeu_pkg::*; ();

	typedef struct packed {
		xeu_byte_t data;
		logic      last;
	} text_beat_t;

	typedef struct packed {
		xeu_byte_t data;
		logic      last;
		logic      known;
		xeu_byte_t want_data;
		logic      want_last;
	} stim_row_t;

	logic clk;
	logic arst_n;

	xeu_in_if  raw_ch ();
	xeu_out_if text_ch ();

	xml_entity_unescape_stream_core dut (
		.clk   (clk),
		.arst_n(arst_n),
		.raw   (raw_ch),
		.text  (text_ch)
	);

	// opening rows: extremes, every entity, stray ampersand, longest flush
	localparam int OPENING_N = 27;
	stim_row_t opening_rows [OPENING_N] = '{
		'{8'h00,   1'b1, 1'b1, 8'h00,   1'b1},
		'{CH_AMP,  1'b0, 1'b0, 8'h00,   1'b0},
		'{CH_AMP,  1'b0, 1'b0, 8'h00,   1'b0},
		'{CH_A,    1'b0, 1'b0, 8'h00,   1'b0},
		'{CH_M,    1'b0, 1'b0, 8'h00,   1'b0},
		'{CH_P,    1'b0, 1'b0, 8'h00,   1'b0},
		'{CH_SEMI, 1'b0, 1'b1, CH_AMP,  1'b0},
		'{CH_AMP,  1'b0, 1'b0, 8'h00,   1'b0},
		'{CH_L,    1'b0, 1'b0, 8'h00,   1'b0},
		'{CH_T,    1'b0, 1'b0, 8'h00,   1'b0},
		'{CH_SEMI, 1'b0, 1'b1, CH_LT,   1'b0},
		'{CH_AMP,  1'b0, 1'b0, 8'h00,   1'b0},
		'{CH_G,    1'b0, 1'b0, 8'h00,   1'b0},
		'{CH_T,    1'b0, 1'b0, 8'h00,   1'b0},
		'{CH_SEMI, 1'b1, 1'b1, CH_GT,   1'b1},
		'{CH_AMP,  1'b0, 1'b0, 8'h00,   1'b0},
		'{CH_Q,    1'b0, 1'b0, 8'h00,   1'b0},
		'{CH_U,    1'b0, 1'b0, 8'h00,   1'b0},
		'{CH_O,    1'b0, 1'b0, 8'h00,   1'b0},
		'{CH_T,    1'b0, 1'b0, 8'h00,   1'b0},
		'{CH_SEMI, 1'b0, 1'b1, CH_QUOT, 1'b0},
		'{CH_AMP,  1'b0, 1'b0, 8'h00,   1'b0},
		'{CH_Q,    1'b0, 1'b0, 8'h00,   1'b0},
		'{CH_U,    1'b0, 1'b0, 8'h00,   1'b0},
		'{CH_O,    1'b0, 1'b0, 8'h00,   1'b0},
		'{CH_T,    1'b0, 1'b0, 8'h00,   1'b0},
		'{8'hff,   1'b1, 1'b0, 8'h00,   1'b0}
	};

	string     ent_name [ENT_COUNT] = '{"&amp;", "&lt;", "&gt;", "&quot;"};
	xeu_byte_t ent_char [ENT_COUNT] = '{CH_AMP, CH_LT, CH_GT, CH_QUOT};

	xeu_byte_t  held_q [HELD_DEPTH];
	int         held_n;
	text_beat_t step_beats[$];
	text_beat_t text_expect_q[$];
	stim_row_t  stim_q[$];
	int         raw_taken;
	int         text_seen;
	int         mismatches;
	bit         calm;
	bit         backlog_hold;
	bit         backlog_done;

	always #2 clk = ~clk;

	function automatic void add_text(xeu_byte_t c);
		stim_q.push_back(stim_row_t'{c, 1'b0, 1'b0, 8'h00, 1'b0});
	endfunction

	function automatic void release_held();
		for (int i = 0; i < held_n; i++)
			step_beats.push_back(text_beat_t'{held_q[i], 1'b0});
		held_n = 0;
	endfunction

	// decode one raw byte into step_beats, advancing the held prefix
	function automatic void unescape_step(xeu_byte_t c, logic fin);
		xeu_byte_t cand [HELD_DEPTH+1];
		int        len;
		int        full;
		bit        prefix;
		bit        same;
		step_beats.delete();
		for (int i = 0; i < held_n; i++)
			cand[i] = held_q[i];
		cand[held_n] = c;
		len = held_n + 1;
		full = -1;
		prefix = 1'b0;
		for (int k = 0; k < ENT_COUNT; k++) begin
			if (len <= ent_name[k].len()) begin
				same = 1'b1;
				for (int j = 0; j < len; j++)
					if (cand[j] != ent_name[k][j])
						same = 1'b0;
				if (same) begin
					if (len == ent_name[k].len())
						full = k;
					else
						prefix = 1'b1;
				end
			end
		end
		if (full >= 0) begin
			held_n = 0;
			step_beats.push_back(text_beat_t'{ent_char[full], 1'b0});
		end else if (prefix && held_n < HELD_DEPTH) begin
			held_q[held_n] = c;
			held_n++;
		end else begin
			release_held();
			// a breaking ampersand opens a fresh match
			if (c == CH_AMP) begin
				held_q[0] = c;
				held_n = 1;
			end else begin
				step_beats.push_back(text_beat_t'{c, 1'b0});
			end
		end
		if (fin) begin
			release_held();
			if (step_beats.size() > 0)
				step_beats[step_beats.size()-1].last = 1'b1;
		end
	endfunction

	// sample at the falling edge: a transfer at the next rising edge is valid && ready now
	always @(negedge clk) begin
		text_beat_t got;
		text_beat_t want;
		if (arst_n) begin
			if (raw_ch.valid && raw_ch.ready) begin
				unescape_step(raw_ch.in_byte, raw_ch.in_last);
				if (stim_q[raw_taken].known)
					text_expect_q.push_back(text_beat_t'{stim_q[raw_taken].want_data,
						stim_q[raw_taken].want_last});
				else
					foreach (step_beats[i])
						text_expect_q.push_back(step_beats[i]);
				raw_taken++;
			end
			if (text_ch.valid && text_ch.ready) begin
				got = text_beat_t'{text_ch.out_byte, text_ch.out_last};
				if (text_expect_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("text byte %0d: unexpected %02h last %0b",
							text_seen, got.data, got.last);
				end else begin
					want = text_expect_q.pop_front();
					if (got.data !== want.data || got.last !== want.last) begin
						mismatches++;
						if (mismatches <= 10)
							$display("text byte %0d: expected %02h last %0b, got %02h last %0b",
								text_seen, want.data, want.last, got.data, got.last);
					end
				end
				text_seen++;
			end
		end
	end

	// receiver: short random stalls, one long hold-off once the random part starts
	initial begin
		text_ch.ready <= 1'b0;
		wait (arst_n);
		forever begin
			if (!backlog_done && raw_taken >= OPENING_N && raw_taken < OPENING_N + 20) begin
				backlog_done = 1'b1;
				backlog_hold = 1'b1;
				text_ch.ready <= 1'b0;
				repeat (80) @(posedge clk);
				backlog_hold = 1'b0;
			end else if (!calm && $urandom_range(0, 4) == 0) begin
				text_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
			end else begin
				text_ch.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	initial begin
		#1_000_000;
		$display("status: fail");
		$finish;
	end

	initial begin
		int  k;
		int  kind;
		int  nseg;
		int  cut;
		bit  taken;
		clk = 1'b0;
		arst_n <= 1'b0;
		raw_ch.valid <= 1'b0;
		raw_ch.in_byte <= 8'h00;
		raw_ch.in_last <= 1'b0;
		held_n = 0;
		raw_taken = 0;
		text_seen = 0;
		mismatches = 0;
		calm = 1'b0;
		backlog_hold = 1'b0;
		backlog_done = 1'b0;

		foreach (opening_rows[i])
			stim_q.push_back(opening_rows[i]);
		// random strings: mostly whole entities, some broken prefixes and raw bytes
		while (stim_q.size() < 250) begin
			nseg = $urandom_range(1, 6);
			for (int s = 0; s < nseg; s++) begin
				kind = $urandom_range(0, 9);
				k = $urandom_range(0, ENT_COUNT - 1);
				if (kind < 5) begin
					for (int j = 0; j < ent_name[k].len(); j++)
						add_text(ent_name[k][j]);
				end else if (kind < 7) begin
					cut = $urandom_range(1, ent_name[k].len() - 1);
					for (int j = 0; j < cut; j++)
						add_text(ent_name[k][j]);
					if ($urandom_range(0, 3) != 0)
						add_text(8'($urandom_range(0, 255)));
				end else if (kind == 7) begin
					add_text(CH_AMP);
				end else begin
					repeat ($urandom_range(1, 3))
						add_text(8'($urandom_range(0, 255)));
				end
			end
			stim_q[stim_q.size()-1].last = 1'b1;
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < stim_q.size(); i++) begin
			if (i >= stim_q.size() - 40)
				calm = 1'b1;
			if (!calm && !backlog_hold && $urandom_range(0, 3) == 0) begin
				raw_ch.valid <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
			end
			raw_ch.valid <= 1'b1;
			raw_ch.in_byte <= stim_q[i].data;
			raw_ch.in_last <= stim_q[i].last;
			// hold the item until a transfer
			do begin
				@(negedge clk);
				taken = raw_ch.ready;
				@(posedge clk);
			end while (!taken);
		end
		raw_ch.valid <= 1'b0;

		while (text_expect_q.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
